>>> rtl/core/bam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bam_pkg;

   localparam int ASK_DEPTH = 64;
   localparam int ADDR_W    = $clog2(ASK_DEPTH);
   localparam int CNT_W     = $clog2(ASK_DEPTH + 1);
   localparam int ID_SHIFT  = 32;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_MATCH = 2'd2;

   localparam logic [1:0] STS_ACTIVE = 2'd0;
   localparam logic [1:0] STS_FILLED = 2'd1;

   localparam logic [15:0] TRADE_CAP_RESET = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] order_ref;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] timestamp;
      logic [1:0]  status;
   } req_type;

   typedef struct packed {
      logic [63:0] fill_ref;
      logic [63:0] bid_ref;
      logic [63:0] ask_ref;
      logic [31:0] trade_price;
      logic [31:0] trade_quantity;
      logic [31:0] trade_time;
      logic [31:0] bid_remaining;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [63:0] id;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] stamp;
      logic [1:0]  status;
   } ask_entry_type;

   typedef struct packed {
      logic [63:0] id;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] stamp;
   } bid_type;

   typedef struct packed {
      logic          hit;
      logic          bid_empty;
      ask_entry_type ask_next;
      rsp_type       trade;
   } eval_type;

endpackage
`default_nettype wire

>>> rtl/core/bam_book.sv
`timescale 1ns / 1ps
`default_nettype none
module bam_book
   import bam_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire ask_entry_type wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output ask_entry_type      rd_data
);

   ask_entry_type mem [ASK_DEPTH];
   ask_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/bam_trade_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module bam_trade_unit
   import bam_pkg::*;
(
   input  wire bid_type       bid,
   input  wire ask_entry_type ask,
   output eval_type           result
);

   logic [31:0] tq;
   logic [31:0] ask_left;
   logic [31:0] bid_left;

   always_comb begin
      tq       = (bid.quantity < ask.quantity) ? bid.quantity : ask.quantity;
      ask_left = ask.quantity - tq;
      bid_left = bid.quantity - tq;

      result.hit = (ask.status == STS_ACTIVE) && (bid.price >= ask.price) && (tq != 32'd0);
      result.bid_empty = (bid_left == 32'd0);

      result.ask_next          = ask;
      result.ask_next.quantity = ask_left;
      if (ask_left == 32'd0) begin
         result.ask_next.status = STS_FILLED;
      end

      result.trade.fill_ref       = {bid.id[63-ID_SHIFT:0], {ID_SHIFT{1'b0}}} | ask.id;
      result.trade.bid_ref        = bid.id;
      result.trade.ask_ref        = ask.id;
      result.trade.trade_price    = ask.price;
      result.trade.trade_quantity = tq;
      result.trade.trade_time     = (bid.stamp > ask.stamp) ? bid.stamp : ask.stamp;
      result.trade.bid_remaining  = bid_left;
      result.trade.last_of_run    = 1'b0;
   end

endmodule
`default_nettype wire

>>> rtl/core/bid_ask_order_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Ask book with bid matching. Clear and load commands finish in the cycle
// they are taken, so busy stays low and another word can follow at once; the
// same holds for a match with an inactive bid or an empty book. Any other
// match raises busy while it scans the held asks in order, then passes
// through ST_FLUSH: the book sits in a memory with a registered read, and
// each ask is read in ST_READ and then goes through the shared compare and
// subtract unit in ST_EVAL, which writes the lowered quantity back on a
// trade. The scan stops early once the bid is filled or the trade cap is
// reached. Trades come out on rsp_item with a one-cycle rsp_valid strobe,
// at most one per cycle (the last two of a run can be back to back); the
// receiver cannot hold them off and must take each as it appears.
// Each trade is held in a pending register so last_of_run can be set on the final one.
module bid_ask_order_matcher
   import bam_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [15:0]       trades_ff, trades_in;
   logic [15:0]       cap_ff, cap_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   bid_type           bid_ff, bid_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   ask_entry_type     wr_data;
   ask_entry_type     rd_data;
   eval_type          eval;
   logic              accept;
   logic              last_idx;

   bam_book u_book (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   bam_trade_unit u_unit (
      .bid    (bid_ff),
      .ask    (rd_data),
      .result (eval)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign last_idx = ({1'b0, idx_ff} + CNT_W'(1)) == held_ff;

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      trades_in     = trades_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      idx_in        = idx_ff;
      bid_in        = bid_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = held_ff[ADDR_W-1:0];
      wr_data.id       = req_item.order_ref;
      wr_data.price    = req_item.price;
      wr_data.quantity = req_item.quantity;
      wr_data.stamp    = req_item.timestamp;
      wr_data.status   = req_item.status;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.command)
                  CMD_CLEAR: begin
                     held_in   = '0;
                     trades_in = '0;
                  end
                  CMD_LOAD: begin
                     if (held_ff < CNT_W'(ASK_DEPTH)) begin
                        wr_en   = 1'b1;
                        held_in = held_ff + CNT_W'(1);
                     end
                  end
                  CMD_MATCH: begin
                     bid_in.id       = req_item.order_ref;
                     bid_in.price    = req_item.price;
                     bid_in.quantity = req_item.quantity;
                     bid_in.stamp    = req_item.timestamp;
                     idx_in          = '0;
                     pend_valid_in   = 1'b0;
                     if (req_item.status == STS_ACTIVE && held_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = last_idx ? ST_FLUSH : ST_READ;
            idx_in   = idx_ff + ADDR_W'(1);
            if (eval.hit) begin
               if (trades_ff >= cap_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  trades_in       = trades_ff + 16'd1;
                  bid_in.quantity = eval.trade.bid_remaining;
                  wr_en           = 1'b1;
                  wr_addr         = idx_ff;
                  wr_data         = eval.ask_next;
                  // previous trade is known not to be the last one
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = eval.trade;
                  if (eval.bid_empty) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
            if (pend_valid_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = pend_ff;
               rsp_in.last_of_run = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         trades_ff     <= '0;
         cap_ff        <= TRADE_CAP_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         trades_ff     <= trades_in;
         cap_ff        <= cap_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      bid_ff  <= bid_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

>>> dv/bid_ask_order_matcher_tb.sv
`timescale 1ns / 1ps
module bid_ask_order_matcher_tb
   import bam_pkg::*;
();

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam logic [1:0] STS_CANCELLED = 2'd2;
   localparam logic [1:0] STS_UNUSED    = 2'd3;
   localparam int SCAN_SETTLE  = 2 * ASK_DEPTH + 12;
   localparam int CYCLE_LIMIT  = 600000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_item = '0;
   logic          rsp_valid;
   rsp_type       rsp_item;
   logic          csr_wr_en = 1'b0;
   logic [15:0]   csr_wr_data = '0;

   // book model
   ask_entry_type book [ASK_DEPTH];
   int            asks_held;
   logic [15:0]   trades_done;
   logic [15:0]   trade_cap;

   rsp_type       pending_trades [$];
   rsp_type       expected_trade;
   int            fail_count = 0;
   int            cycle_count = 0;
   int            sender_idle_pct = 0;

   bid_ask_order_matcher u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type make_word(logic [1:0] cmd, logic [63:0] id, logic [31:0] price,
                                         logic [31:0] qty, logic [31:0] stamp,
                                         logic [1:0] status);
      req_type w;
      w.command   = cmd;
      w.order_ref = id;
      w.price     = price;
      w.quantity  = qty;
      w.timestamp = stamp;
      w.status    = status;
      return w;
   endfunction

   // works out the trades one word causes and queues them in scan order
   function automatic void predict_trades(req_type w);
      rsp_type     t;
      rsp_type     prev;
      bit          have_prev;
      logic [31:0] left;
      logic [31:0] tq;
      have_prev = 1'b0;
      prev = '0;
      case (w.command)
         CMD_CLEAR: begin
            asks_held = 0;
            trades_done = '0;
         end
         CMD_LOAD: begin
            if (asks_held < ASK_DEPTH) begin
               book[asks_held].id       = w.order_ref;
               book[asks_held].price    = w.price;
               book[asks_held].quantity = w.quantity;
               book[asks_held].stamp    = w.timestamp;
               book[asks_held].status   = w.status;
               asks_held++;
            end
         end
         CMD_MATCH: begin
            if (w.status == STS_ACTIVE) begin
               left = w.quantity;
               for (int i = 0; i < asks_held; i++) begin
                  if (book[i].status != STS_ACTIVE || w.price < book[i].price)
                     continue;
                  tq = (left < book[i].quantity) ? left : book[i].quantity;
                  if (tq == 0)
                     continue;
                  if (trades_done >= trade_cap)
                     break;
                  trades_done = trades_done + 16'd1;
                  left = left - tq;
                  book[i].quantity = book[i].quantity - tq;
                  if (book[i].quantity == 0)
                     book[i].status = STS_FILLED;
                  t.fill_ref       = {w.order_ref[31:0], 32'h0} | book[i].id;
                  t.bid_ref        = w.order_ref;
                  t.ask_ref        = book[i].id;
                  t.trade_price    = book[i].price;
                  t.trade_quantity = tq;
                  t.trade_time     = (w.timestamp > book[i].stamp) ? w.timestamp : book[i].stamp;
                  t.bid_remaining  = left;
                  t.last_of_run    = 1'b0;
                  // hold each trade back until we know whether another follows
                  if (have_prev)
                     pending_trades.insert(pending_trades.size(), prev);
                  prev = t;
                  have_prev = 1'b1;
                  if (left == 0)
                     break;
               end
               if (have_prev) begin
                  prev.last_of_run = 1'b1;
                  pending_trades.insert(pending_trades.size(), prev);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_trades.size() == 0) begin
            $error("fill_ref expected none actual %0h", rsp_item.fill_ref);
            fail_count++;
         end else begin
            expected_trade = pending_trades.pop_front();
            compare_field("fill_ref", expected_trade.fill_ref, rsp_item.fill_ref);
            compare_field("bid_ref", expected_trade.bid_ref, rsp_item.bid_ref);
            compare_field("ask_ref", expected_trade.ask_ref, rsp_item.ask_ref);
            compare_field("trade_price", 64'(expected_trade.trade_price),
                          64'(rsp_item.trade_price));
            compare_field("trade_quantity", 64'(expected_trade.trade_quantity),
                          64'(rsp_item.trade_quantity));
            compare_field("trade_time", 64'(expected_trade.trade_time),
                          64'(rsp_item.trade_time));
            compare_field("bid_remaining", 64'(expected_trade.bid_remaining),
                          64'(rsp_item.bid_remaining));
            compare_field("last_of_run", 64'(expected_trade.last_of_run),
                          64'(rsp_item.last_of_run));
         end
      end
   end

   task automatic send_word(req_type w);
      req_item <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_trades(w);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop sending and let every expected trade come out, then let a scan finish
   task automatic wait_book_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_trades.size() != 0 || busy !== 1'b0);
      repeat (SCAN_SETTLE) @(posedge clock);
   endtask

   task automatic write_cap(logic [15:0] value);
      wait_book_idle();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      trade_cap = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_qty();
      int roll;
      roll = $urandom_range(15);
      if (roll == 0)
         return 32'd0;
      if (roll < 3)
         return $urandom;
      return $urandom_range(1, 50);
   endfunction

   function automatic logic [1:0] pick_status();
      if ($urandom_range(4) != 0)
         return STS_ACTIVE;
      return 2'($urandom_range(1, 3));
   endfunction

   task automatic test_field_extremes();
      write_cap(16'hFFFF);
      send_word(make_word(CMD_CLEAR, '0, '0, '0, '0, STS_ACTIVE));
      send_word(make_word(CMD_LOAD, '1, 32'd0, 32'hFFFF_FFFF, 32'd0, STS_ACTIVE));
      send_word(make_word(CMD_LOAD, '0, 32'd100, 32'd5, 32'hFFFF_FFFF, STS_FILLED));
      send_word(make_word(CMD_LOAD, 64'h11, 32'd100, 32'd5, 32'd7, STS_CANCELLED));
      send_word(make_word(CMD_LOAD, 64'h22, 32'd100, 32'd5, 32'd7, STS_UNUSED));
      send_word(make_word(CMD_LOAD, 64'h33, 32'd0, 32'd0, 32'd7, STS_ACTIVE));
      send_word(make_word(CMD_LOAD, 64'h44, 32'hFFFF_FFFF, 32'd7, 32'd9, STS_ACTIVE));
      send_word(make_word(CMD_LOAD, 64'h55, 32'd50, 32'd10, 32'd1000, STS_ACTIVE));
      send_word(make_word(CMD_MATCH, '1, 32'd49, 32'd3, 32'd500, STS_ACTIVE));
      send_word(make_word(CMD_MATCH, 64'hA5A5_0000_5A5A_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, STS_ACTIVE));
      // inactive bids and the unused command produce nothing
      send_word(make_word(CMD_MATCH, 64'h1, 32'hFFFF_FFFF, 32'd9, 32'd0, STS_FILLED));
      send_word(make_word(CMD_MATCH, 64'h2, 32'hFFFF_FFFF, 32'd9, 32'd0, STS_CANCELLED));
      send_word(make_word(CMD_MATCH, 64'h3, 32'hFFFF_FFFF, 32'd9, 32'd0, STS_UNUSED));
      send_word(make_word(CMD_UNUSED, '1, '1, '1, '1, STS_UNUSED));
      send_word(make_word(CMD_MATCH, 64'h4, 32'hFFFF_FFFF, 32'd0, 32'd0, STS_ACTIVE));
      // bid and ask fill together
      send_word(make_word(CMD_MATCH, 64'h5, 32'd50, 32'd10, 32'd0, STS_ACTIVE));
      send_word(make_word(CMD_MATCH, 64'h6, 32'hFFFF_FFFF, 32'd4, 32'd3, STS_ACTIVE));
      send_word(make_word(CMD_MATCH, 64'h7, 32'hFFFF_FFFF, 32'd4, 32'd3, STS_ACTIVE));
   endtask

   task automatic test_book_full();
      send_word(make_word(CMD_CLEAR, '0, '0, '0, '0, STS_ACTIVE));
      for (int i = 0; i < ASK_DEPTH + 2; i++)
         send_word(make_word(CMD_LOAD, {$urandom, $urandom}, 32'(i), 32'd1, $urandom,
                             STS_ACTIVE));
      // sweeps the whole book, one trade per ask
      send_word(make_word(CMD_MATCH, {$urandom, $urandom}, 32'hFFFF_FFFF, 32'd1000, $urandom,
                          STS_ACTIVE));
   endtask

   task automatic test_trade_cap();
      write_cap(16'd0);
      send_word(make_word(CMD_CLEAR, '0, '0, '0, '0, STS_ACTIVE));
      for (int i = 0; i < 3; i++)
         send_word(make_word(CMD_LOAD, 64'(i + 8), 32'd10, 32'd5, 32'd1, STS_ACTIVE));
      send_word(make_word(CMD_MATCH, 64'h70, 32'd10, 32'd100, 32'd2, STS_ACTIVE));
      write_cap(16'd2);
      send_word(make_word(CMD_MATCH, 64'h71, 32'd10, 32'd100, 32'd2, STS_ACTIVE));
      send_word(make_word(CMD_MATCH, 64'h72, 32'd10, 32'd100, 32'd2, STS_ACTIVE));
      // cap now below the count already reached
      write_cap(16'd1);
      send_word(make_word(CMD_MATCH, 64'h73, 32'd10, 32'd100, 32'd2, STS_ACTIVE));
      send_word(make_word(CMD_CLEAR, '0, '0, '0, '0, STS_ACTIVE));
      send_word(make_word(CMD_LOAD, 64'h9, 32'd10, 32'd5, 32'd1, STS_ACTIVE));
      send_word(make_word(CMD_MATCH, 64'h74, 32'd10, 32'd100, 32'd2, STS_ACTIVE));
      write_cap(16'hFFFF);
   endtask

   task automatic test_random_traffic(int word_goal, int idle_pct);
      int          sent;
      int          loads;
      int          bids;
      logic [31:0] base;
      logic [31:0] bid_price;
      logic [15:0] cap_pick;
      bit          drained;
      sent = 0;
      drained = 1'b0;
      case ($urandom_range(2))
         0: cap_pick = 16'hFFFF;
         1: cap_pick = 16'($urandom_range(1, 12));
         default: cap_pick = 16'($urandom);
      endcase
      write_cap(cap_pick);
      sender_idle_pct = idle_pct;
      while (sent < word_goal) begin
         if (sent == 0 || $urandom_range(2) == 0) begin
            send_word(make_word(CMD_CLEAR, {$urandom, $urandom}, $urandom, $urandom, $urandom,
                                2'($urandom)));
            sent++;
         end
         base = $urandom_range(0, 32'hFFFF_FF00);
         loads = $urandom_range(1, 10);
         for (int i = 0; i < loads; i++) begin
            send_word(make_word(CMD_LOAD, {$urandom, $urandom}, base + $urandom_range(0, 40),
                                pick_qty(), $urandom, pick_status()));
            sent++;
         end
         bids = $urandom_range(1, 4);
         for (int i = 0; i < bids; i++) begin
            bid_price = ($urandom_range(7) == 0) ? $urandom : base + $urandom_range(0, 60);
            send_word(make_word(CMD_MATCH, {$urandom, $urandom}, bid_price, pick_qty(),
                                $urandom, pick_status()));
            sent++;
         end
         if ($urandom_range(5) == 0)
            send_word(make_word(CMD_UNUSED, {$urandom, $urandom}, $urandom, $urandom, $urandom,
                                2'($urandom)));
         if (!drained && sent > word_goal / 2) begin
            wait_book_idle();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      trade_cap = TRADE_CAP_RESET;
      trades_done = '0;
      asks_held = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 27;
      test_field_extremes();
      test_book_full();
      test_trade_cap();
      test_random_traffic(6, 27);
      test_random_traffic(6, 76);
      test_random_traffic(6, 0);
      wait_book_idle();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/core/bam_pkg.sv
rtl/core/bam_book.sv
rtl/core/bam_trade_unit.sv
rtl/core/bid_ask_order_matcher.sv
dv/bid_ask_order_matcher_tb.sv
